@@ rtl/igpd_pkg.sv @@
// Shared types, constants and field decode helpers for the IMU/GPS packet deframer.
package igpd_pkg;

    localparam int POS_W   = 7;
    localparam int QTY_W   = 5;
    localparam int VAL_W   = 32;
    localparam int TALLY_W = 16;

    localparam logic [7:0] HDR_BYTE = 8'h55;
    localparam logic [7:0] TYPE_S   = 8'h53;
    localparam logic [7:0] TYPE_N   = 8'h4E;
    localparam logic [7:0] TYPE_G   = 8'h47;

    localparam logic [POS_W-1:0] LEN_S        = 7'd51;
    localparam logic [POS_W-1:0] LEN_N        = 7'd86;
    localparam logic [POS_W-1:0] BODY_START   = 7'd3;
    localparam logic [POS_W-1:0] MARK_POS_0   = 7'd31;
    localparam logic [POS_W-1:0] MARK_POS_1   = 7'd32;
    localparam logic [POS_W-1:0] MARK_POS_2   = 7'd33;
    localparam logic [POS_W-1:0] IMU_BASE     = 7'd3;
    localparam logic [POS_W-1:0] PRESS_BASE   = 7'd27;
    localparam logic [POS_W-1:0] SERVO_BASE_S = 7'd32;
    localparam logic [POS_W-1:0] SERVO_BASE_N = 7'd67;
    localparam logic [POS_W-1:0] GPS_BASE     = 7'd34;
    localparam logic [POS_W-1:0] GPS_TIME_POS = 7'd58;

    localparam logic [QTY_W-1:0] Q_PRESS_FIRST = 5'd9;
    localparam logic [QTY_W-1:0] Q_SERVO_STAT  = 5'd11;
    localparam logic [QTY_W-1:0] Q_SERVO_FIRST = 5'd12;
    localparam logic [QTY_W-1:0] Q_SERVO_LAST  = 5'd19;
    localparam logic [QTY_W-1:0] Q_GPS_FIRST   = 5'd20;
    localparam logic [QTY_W-1:0] Q_GPS_TIME    = 5'd26;

    typedef enum logic [1:0] {
        ST_DATA     = 2'd0,
        ST_CSUM_ERR = 2'd1,
        ST_BAD_TYPE = 2'd2,
        ST_NO_GPS   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FMT_BE16S,
        FMT_BE16U,
        FMT_U8,
        FMT_LE32,
        FMT_LE16U
    } fmt_t;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_BYTE,
        SRC_FIELD
    } src_t;

    typedef struct packed {
        logic [POS_W-1:0] offset;
        logic [1:0]       last_idx;
        fmt_t             fmt;
    } field_desc_t;

    typedef struct packed {
        logic             mem_we;
        logic [POS_W-1:0] mem_addr;
        logic             shift;
        logic             sum_load;
        logic             sum_add;
        logic             tally_inc;
        logic             mark_upd;
        logic             out_load;
        status_t          out_status;
        logic [QTY_W-1:0] out_qty;
        src_t             out_src;
        fmt_t             fmt;
    } dp_cmd_t;

    typedef struct packed {
        logic is_hdr;
        logic is_s;
        logic is_n;
        logic sum_ok;
        logic marker_ok;
    } dp_sts_t;

    function automatic field_desc_t field_desc(input logic [QTY_W-1:0] qty,
                                               input logic             kind_n);
        field_desc_t      d;
        logic [POS_W-1:0] q7;
        logic [POS_W-1:0] sbase;
        q7    = POS_W'(qty);
        sbase = kind_n ? SERVO_BASE_N : SERVO_BASE_S;
        priority if (qty < Q_PRESS_FIRST) begin
            d.offset   = IMU_BASE + POS_W'(q7 << 1);
            d.last_idx = 2'd1;
            d.fmt      = FMT_BE16S;
        end
        else if (qty < Q_SERVO_STAT) begin
            d.offset   = PRESS_BASE + POS_W'((q7 - POS_W'(Q_PRESS_FIRST)) << 1);
            d.last_idx = 2'd1;
            d.fmt      = FMT_BE16S;
        end
        else if (qty == Q_SERVO_STAT) begin
            d.offset   = sbase;
            d.last_idx = 2'd0;
            d.fmt      = FMT_U8;
        end
        else if (qty < Q_GPS_FIRST) begin
            d.offset   = sbase + 7'd1 + POS_W'((q7 - POS_W'(Q_SERVO_FIRST)) << 1);
            d.last_idx = 2'd1;
            d.fmt      = FMT_BE16U;
        end
        else if (qty < Q_GPS_TIME) begin
            d.offset   = GPS_BASE + POS_W'((q7 - POS_W'(Q_GPS_FIRST)) << 2);
            d.last_idx = 2'd3;
            d.fmt      = FMT_LE32;
        end
        else begin
            d.offset   = GPS_TIME_POS;
            d.last_idx = 2'd1;
            d.fmt      = FMT_LE16U;
        end
        return d;
    endfunction

    function automatic logic [VAL_W-1:0] format_field(input logic [VAL_W-1:0] acc,
                                                      input fmt_t             fmt);
        logic [VAL_W-1:0] v;
        unique case (fmt)
            FMT_BE16S: v = {{16{acc[15]}}, acc[15:0]};
            FMT_BE16U: v = {16'd0, acc[15:0]};
            FMT_U8:    v = {24'd0, acc[7:0]};
            FMT_LE32:  v = acc;
            FMT_LE16U: v = {16'd0, acc[31:16]};
            default:   v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/igpd_dp.sv @@
// Datapath of the deframer: packet store, checksum, tally, field assembly and result register.
module igpd_dp #(
    parameter int PACKET_BUFFER_DEPTH = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [7:0]                    in_data,
    input  igpd_pkg::dp_cmd_t             cmd,
    output igpd_pkg::dp_sts_t             sts,
    output igpd_pkg::status_t             out_status,
    output logic [igpd_pkg::QTY_W-1:0]    out_qty,
    output logic signed [igpd_pkg::VAL_W-1:0] out_value,
    output logic [igpd_pkg::TALLY_W-1:0]  tally
);

    localparam int AW = $clog2(PACKET_BUFFER_DEPTH);

    logic [7:0]                   mem [PACKET_BUFFER_DEPTH];
    logic [7:0]                   rd_data_reg;
    logic [AW-1:0]                addr;
    logic [15:0]                  sum_reg;
    logic [7:0]                   prev_reg;
    logic                         marker_reg;
    logic [igpd_pkg::TALLY_W-1:0] tally_reg;
    logic [igpd_pkg::VAL_W-1:0]   acc_reg;
    igpd_pkg::status_t            status_reg;
    logic [igpd_pkg::QTY_W-1:0]   qty_reg;
    logic [igpd_pkg::VAL_W-1:0]   value_reg;
    logic                         is_hdr;

    assign addr   = AW'(cmd.mem_addr);
    assign is_hdr = (in_data == igpd_pkg::HDR_BYTE);

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[addr] <= in_data;
        end
        rd_data_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            prev_reg   <= '0;
            marker_reg <= 1'b0;
            tally_reg  <= '0;
        end
        else
        begin
            if (cmd.sum_load)
            begin
                sum_reg <= {8'd0, in_data};
            end
            else if (cmd.sum_add)
            begin
                sum_reg <= sum_reg + {8'd0, in_data};
            end
            if (cmd.mem_we)
            begin
                prev_reg <= in_data;
            end
            if (cmd.mark_upd)
            begin
                if (cmd.mem_addr == igpd_pkg::MARK_POS_0)
                begin
                    marker_reg <= is_hdr;
                end
                else if (cmd.mem_addr == igpd_pkg::MARK_POS_1)
                begin
                    marker_reg <= marker_reg & is_hdr;
                end
                else if (cmd.mem_addr == igpd_pkg::MARK_POS_2)
                begin
                    marker_reg <= marker_reg & (in_data == igpd_pkg::TYPE_G);
                end
            end
            if (cmd.tally_inc && (tally_reg != '1))
            begin
                tally_reg <= tally_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            if (cmd.fmt == igpd_pkg::FMT_LE32 || cmd.fmt == igpd_pkg::FMT_LE16U)
            begin
                acc_reg <= {rd_data_reg, acc_reg[igpd_pkg::VAL_W-1:8]};
            end
            else
            begin
                acc_reg <= {acc_reg[igpd_pkg::VAL_W-9:0], rd_data_reg};
            end
        end
        if (cmd.out_load)
        begin
            status_reg <= cmd.out_status;
            qty_reg    <= cmd.out_qty;
            unique case (cmd.out_src)
                igpd_pkg::SRC_BYTE:  value_reg <= {24'd0, in_data};
                igpd_pkg::SRC_FIELD: value_reg <= igpd_pkg::format_field(acc_reg, cmd.fmt);
                default:             value_reg <= '0;
            endcase
        end
    end

    assign sts.is_hdr    = is_hdr;
    assign sts.is_s      = (in_data == igpd_pkg::TYPE_S);
    assign sts.is_n      = (in_data == igpd_pkg::TYPE_N);
    assign sts.sum_ok    = (sum_reg == {prev_reg, in_data});
    assign sts.marker_ok = marker_reg;

    assign out_status = status_reg;
    assign out_qty    = qty_reg;
    assign out_value  = value_reg;
    assign tally      = tally_reg;

endmodule

@@ rtl/igpd_ctrl.sv @@
// Controller of the deframer: header hunt, body count and result sequencing.
module igpd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_last,
    input  igpd_pkg::dp_sts_t   sts,
    output igpd_pkg::dp_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_RECV,
        S_FETCH,
        S_LAST,
        S_LOAD,
        S_SHOW
    } state_t;

    typedef enum logic [1:0] {
        H_HDR0,
        H_HDR1,
        H_TYPE,
        H_BODY
    } hunt_t;

    state_t                          state_reg, state_next;
    hunt_t                           phase_reg, phase_next;
    logic                            kind_reg, kind_next;
    logic [igpd_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [igpd_pkg::QTY_W-1:0]      qty_reg, qty_next;
    logic [1:0]                      cnt_reg, cnt_next;
    logic                            last_reg, last_next;
    logic                            shift_reg;
    logic [igpd_pkg::POS_W-1:0]      len;
    igpd_pkg::field_desc_t           desc;

    assign len  = kind_reg ? igpd_pkg::LEN_N : igpd_pkg::LEN_S;
    assign desc = igpd_pkg::field_desc(qty_reg, kind_reg);

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        pos_next     = pos_reg;
        qty_next     = qty_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        cmd          = '0;
        cmd.mem_addr = pos_reg;
        cmd.out_qty  = qty_reg;
        cmd.fmt      = desc.fmt;
        cmd.shift    = shift_reg;
        unique case (state_reg)
            S_RECV:
            begin
                if (in_valid)
                begin
                    unique case (phase_reg)
                        H_HDR0:
                        begin
                            if (sts.is_hdr)
                            begin
                                phase_next = H_HDR1;
                            end
                        end
                        H_HDR1:
                        begin
                            phase_next = sts.is_hdr ? H_TYPE : H_HDR0;
                        end
                        H_TYPE:
                        begin
                            if (sts.is_s || sts.is_n)
                            begin
                                kind_next    = sts.is_n;
                                cmd.sum_load = 1'b1;
                                pos_next     = igpd_pkg::BODY_START;
                                phase_next   = H_BODY;
                            end
                            else
                            begin
                                cmd.tally_inc  = 1'b1;
                                cmd.out_load   = 1'b1;
                                cmd.out_status = igpd_pkg::ST_BAD_TYPE;
                                cmd.out_qty    = '0;
                                cmd.out_src    = igpd_pkg::SRC_BYTE;
                                last_next      = 1'b1;
                                phase_next     = H_HDR0;
                                state_next     = S_SHOW;
                            end
                        end
                        H_BODY:
                        begin
                            cmd.mem_we   = 1'b1;
                            cmd.mark_upd = 1'b1;
                            cmd.sum_add  = (pos_reg <= len - 7'd3);
                            pos_next     = pos_reg + 1'b1;
                            if (pos_reg == len - 7'd1)
                            begin
                                phase_next = H_HDR0;
                                pos_next   = '0;
                                if (sts.sum_ok)
                                begin
                                    qty_next   = '0;
                                    cnt_next   = '0;
                                    state_next = S_FETCH;
                                end
                                else
                                begin
                                    cmd.out_load   = 1'b1;
                                    cmd.out_status = igpd_pkg::ST_CSUM_ERR;
                                    cmd.out_qty    = '0;
                                    cmd.out_src    = igpd_pkg::SRC_ZERO;
                                    last_next      = 1'b1;
                                    state_next     = S_SHOW;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = H_HDR0;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                cmd.mem_addr = desc.offset + igpd_pkg::POS_W'(cnt_reg);
                if (cnt_reg == desc.last_idx)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_LAST:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.out_load   = 1'b1;
                cmd.out_status = igpd_pkg::ST_DATA;
                cmd.out_src    = igpd_pkg::SRC_FIELD;
                last_next      = ((qty_reg == igpd_pkg::Q_SERVO_LAST) && !kind_reg) ||
                                 (qty_reg == igpd_pkg::Q_GPS_TIME);
                state_next     = S_SHOW;
            end
            S_SHOW:
            begin
                if (out_ready)
                begin
                    if (last_reg)
                    begin
                        state_next = S_RECV;
                    end
                    else if ((qty_reg == igpd_pkg::Q_SERVO_LAST) && !sts.marker_ok)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = igpd_pkg::ST_NO_GPS;
                        cmd.out_qty    = '0;
                        cmd.out_src    = igpd_pkg::SRC_ZERO;
                        last_next      = 1'b1;
                    end
                    else
                    begin
                        qty_next   = qty_reg + 1'b1;
                        cnt_next   = '0;
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_RECV;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RECV;
            phase_reg <= H_HDR0;
            kind_reg  <= 1'b0;
            pos_reg   <= '0;
            qty_reg   <= '0;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            shift_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            pos_reg   <= pos_next;
            qty_reg   <= qty_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            shift_reg <= (state_reg == S_FETCH);
        end
    end

    assign in_ready  = (state_reg == S_RECV);
    assign out_valid = (state_reg == S_SHOW);
    assign out_last  = last_reg;

endmodule

@@ rtl/imu_gps_packet_deframer.sv @@
// Top level of the IMU/GPS serial packet deframer with additive checksum.
//
// Channel   Dir  Signals                       Contents
// s_axis    in   tvalid tready tdata[7:0]      rx_byte
// m_axis    out  tvalid tready tdata tuser     status, quantity, value, bad_type_total
//                tlast                         last
//
// Bytes are taken while a packet is received and refused while results drain.
// Each result field is read from the store byte by byte, assembled and loaded into
// the result register for its output transaction; an 'S' packet drains quantities
// 0 to 19, an 'N' packet adds GPS or a no-GPS result; a bad type or bad sum gives one.
// Reset clears the hunt, checksum and tally; the packet store needs no clearing.
// A stalled output holds the result and the input stays refused until it is taken.
module imu_gps_packet_deframer #(
    parameter int PACKET_BUFFER_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] value, [47:32] bad_type_total
    output logic [6:0]  m_axis_tuser,   // [1:0] status, [6:2] quantity
    output logic        m_axis_tlast
);

    igpd_pkg::dp_cmd_t                       cmd;
    igpd_pkg::dp_sts_t                       sts;
    igpd_pkg::status_t                       out_status;
    logic [igpd_pkg::QTY_W-1:0]              out_qty;
    logic signed [igpd_pkg::VAL_W-1:0]       out_value;
    logic [igpd_pkg::TALLY_W-1:0]            tally;

    igpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_last  (m_axis_tlast),
        .sts       (sts),
        .cmd       (cmd)
    );

    igpd_dp #(
        .PACKET_BUFFER_DEPTH (PACKET_BUFFER_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_data    (s_axis_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .out_status (out_status),
        .out_qty    (out_qty),
        .out_value  (out_value),
        .tally      (tally)
    );

    assign m_axis_tdata = {tally, out_value};
    assign m_axis_tuser = {out_qty, out_status};

endmodule
